[src/lci_pkg.sv]
// lci_pkg: shared types and constants for the line/circle intersection block.
// No dependencies.
`default_nettype none
package lci_pkg;

    localparam int N_LANES  = 4;
    localparam int LANE_P0X = 0;
    localparam int LANE_P0Y = 1;
    localparam int LANE_P1X = 2;
    localparam int LANE_P1Y = 3;

    typedef struct packed {
        logic keep0;
        logic keep1;
        logic zero_len;
    } lci_sel_t;

endpackage
`default_nettype wire

[src/lci_if.sv]
// lci_if: request and result channel interfaces (valid/ready plus payload).
// No dependencies.
`default_nettype none
interface lci_in_if #(parameter int CW = 16);
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic        [CW-2:0] radius;

    modport source (output valid, func, start_x, start_y, end_x, end_y,
                    center_x, center_y, radius, input ready);
    modport sink   (input valid, func, start_x, start_y, end_x, end_y,
                    center_x, center_y, radius, output ready);
endinterface

interface lci_out_if #(parameter int CW = 16);
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [1:0]           point_count;
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic                 zero_length;

    modport source (output valid, hit, point_count, first_x, first_y, second_x,
                    second_y, zero_length, input ready);
    modport sink   (input valid, hit, point_count, first_x, first_y, second_x,
                    second_y, zero_length, output ready);
endinterface
`default_nettype wire

[src/lci_quad.sv]
// lci_quad: six-stage front end, forms a = D.D, h = D.P and q = h^2 - a*c.
// Wide products are split into halves over two stages. No package use.
`default_nettype none
module lci_quad #(
    parameter int CW = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic                    in_func,
    input  logic signed [CW-1:0]    sx,
    input  logic signed [CW-1:0]    sy,
    input  logic signed [CW-1:0]    ex,
    input  logic signed [CW-1:0]    ey,
    input  logic signed [CW-1:0]    cx,
    input  logic signed [CW-1:0]    cy,
    input  logic        [CW-2:0]    r,
    output logic                    out_valid,
    output logic                    out_func,
    output logic signed [4*CW+3:0]  q,
    output logic        [2*CW:0]    a,
    output logic signed [2*CW+1:0]  h,
    output logic signed [CW-1:0]    out_sx,
    output logic signed [CW-1:0]    out_sy,
    output logic signed [CW:0]      dx,
    output logic signed [CW:0]      dy
);
    localparam int DW  = CW + 1;
    localparam int PW2 = 2 * DW;
    localparam int AW  = 2 * CW + 1;
    localparam int HW  = 2 * CW + 2;
    localparam int QW  = 4 * CW + 4;
    localparam int L   = CW + 1;
    localparam int UW  = 2 * L;
    localparam int SDW = 1 + 2 * CW + 2 * DW;

    logic [5:0] v_reg;

    logic [SDW-1:0] side_reg [6];

    logic signed [DW-1:0]  s1_px_reg, s1_py_reg;
    logic        [CW-2:0]  s1_r_reg;

    logic signed [PW2-1:0] s2_pxx_reg, s2_pyy_reg, s2_dxx_reg, s2_dyy_reg;
    logic signed [PW2-1:0] s2_dxp_reg, s2_dyp_reg;
    logic [2*CW-3:0]       s2_rr_reg;

    logic        [AW-1:0]  a_reg [4];
    logic signed [HW-1:0]  h_reg [4];
    logic signed [HW-1:0]  s3_c_reg;

    logic [HW-1:0]         hm, cm;
    logic [UW-1:0]         s4_hh_ll_reg, s4_hh_lh_reg, s4_hh_hh_reg;
    logic [UW-1:0]         s4_ac_ll_reg, s4_ac_lh_reg, s4_ac_hl_reg, s4_ac_hh_reg;
    logic                  s4_cneg_reg, s5_cneg_reg;

    logic [QW-1:0]         s5_hh_reg, s5_ac_reg;
    logic signed [QW-1:0]  s6_q_reg;

    logic signed [DW-1:0]  s1_dx, s1_dy;

    assign s1_dx = DW'(ex) - DW'(sx);
    assign s1_dy = DW'(ey) - DW'(sy);
    assign hm    = h_reg[0][HW-1] ? HW'(-h_reg[0]) : HW'(h_reg[0]);
    assign cm    = s3_c_reg[HW-1] ? HW'(-s3_c_reg) : HW'(s3_c_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: differences
            side_reg[0] <= {in_func, sx, sy, s1_dx, s1_dy};
            s1_px_reg   <= DW'(sx) - DW'(cx);
            s1_py_reg   <= DW'(sy) - DW'(cy);
            s1_r_reg    <= r;
            for (int i = 1; i < 6; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end

            // stage 2: products
            s2_pxx_reg <= s1_px_reg * s1_px_reg;
            s2_pyy_reg <= s1_py_reg * s1_py_reg;
            s2_dxx_reg <= $signed(side_reg[0][2*DW-1:DW]) * $signed(side_reg[0][2*DW-1:DW]);
            s2_dyy_reg <= $signed(side_reg[0][DW-1:0]) * $signed(side_reg[0][DW-1:0]);
            s2_dxp_reg <= $signed(side_reg[0][2*DW-1:DW]) * s1_px_reg;
            s2_dyp_reg <= $signed(side_reg[0][DW-1:0]) * s1_py_reg;
            s2_rr_reg  <= s1_r_reg * s1_r_reg;

            // stage 3: a, h, c
            a_reg[0] <= AW'(s2_dxx_reg) + AW'(s2_dyy_reg);
            h_reg[0] <= s2_dxp_reg + s2_dyp_reg;
            s3_c_reg <= s2_pxx_reg + s2_pyy_reg - $signed(HW'(s2_rr_reg));
            for (int i = 1; i < 4; i++)
            begin
                a_reg[i] <= a_reg[i-1];
                h_reg[i] <= h_reg[i-1];
            end

            // stage 4: half-width partial products of h*h and a*|c|
            s4_hh_ll_reg <= hm[L-1:0] * hm[L-1:0];
            s4_hh_lh_reg <= hm[L-1:0] * hm[HW-1:L];
            s4_hh_hh_reg <= hm[HW-1:L] * hm[HW-1:L];
            s4_ac_ll_reg <= a_reg[0][L-1:0] * cm[L-1:0];
            s4_ac_lh_reg <= a_reg[0][L-1:0] * cm[HW-1:L];
            s4_ac_hl_reg <= a_reg[0][AW-1:L] * cm[L-1:0];
            s4_ac_hh_reg <= a_reg[0][AW-1:L] * cm[HW-1:L];
            s4_cneg_reg  <= s3_c_reg[HW-1];

            // stage 5: recombine
            s5_hh_reg   <= QW'(s4_hh_ll_reg) + (QW'(s4_hh_lh_reg) << (L + 1))
                         + (QW'(s4_hh_hh_reg) << (2 * L));
            s5_ac_reg   <= QW'(s4_ac_ll_reg)
                         + ((QW'(s4_ac_lh_reg) + QW'(s4_ac_hl_reg)) << L)
                         + (QW'(s4_ac_hh_reg) << (2 * L));
            s5_cneg_reg <= s4_cneg_reg;

            // stage 6: quarter discriminant
            s6_q_reg <= s5_cneg_reg ? $signed(s5_hh_reg + s5_ac_reg)
                                    : $signed(s5_hh_reg - s5_ac_reg);
        end
    end

    assign out_valid = v_reg[5];
    assign q         = s6_q_reg;
    assign a         = a_reg[3];
    assign h         = h_reg[3];
    assign {out_func, out_sx, out_sy, dx, dy} = side_reg[5];

endmodule
`default_nettype wire

[src/lci_sqrt.sv]
// lci_sqrt: pipelined integer square root, one root bit per stage.
// No package use.
`default_nettype none
module lci_sqrt #(
    parameter int QW = 68,
    parameter int PW = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [QW-1:0]     rad,
    input  logic [PW-1:0]     in_pay,
    output logic              out_valid,
    output logic [QW/2-1:0]   root,
    output logic [PW-1:0]     out_pay
);
    localparam int SW = QW / 2;
    localparam int RW = SW + 2;

    logic [SW-1:0] v_reg;
    logic [QW-1:0] rad_reg  [SW-1];
    logic [RW-1:0] rem_reg  [SW-1];
    logic [SW-1:0] root_reg [SW];
    logic [PW-1:0] pay_reg  [SW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[SW-2:0], in_valid};
        end
    end

    for (genvar i = 0; i < SW; i++)
    begin : g_stage
        logic [QW-1:0] rad_in;
        logic [RW-1:0] rem_in;
        logic [SW-1:0] root_in;
        logic [PW-1:0] pay_in;
        logic [RW-1:0] cur;
        logic [RW-1:0] trial;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign rad_in  = rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign pay_in  = in_pay;
        end
        else
        begin : g_rest
            assign rad_in  = rad_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign pay_in  = pay_reg[i-1];
        end

        assign cur   = {rem_in[RW-3:0], rad_in[QW-1:QW-2]};
        assign trial = {root_in, 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[i] <= {root_in[SW-2:0], ge};
                pay_reg[i]  <= pay_in;
            end
        end

        if (i < SW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[i] <= rad_in << 2;
                    rem_reg[i] <= ge ? cur - trial : cur;
                end
            end
        end
    end

    assign out_valid = v_reg[SW-1];
    assign root      = root_reg[SW-1];
    assign out_pay   = pay_reg[SW-1];

endmodule
`default_nettype wire

[src/lci_numer.sv]
// lci_numer: three stages from root to division operands; root selection,
// segment test, split products |Dk|*|n| and rounding bias. Uses lci_pkg.
`default_nettype none
module lci_numer #(
    parameter int CW = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [2*CW+1:0]         s,
    input  logic [2*CW:0]           a,
    input  logic signed [2*CW+1:0]  h,
    input  logic signed [CW-1:0]    sx,
    input  logic signed [CW-1:0]    sy,
    input  logic signed [CW:0]      dx,
    input  logic signed [CW:0]      dy,
    input  logic                    func,
    input  logic                    zl,
    input  logic                    qneg,
    input  logic                    qzero,
    output logic                    out_valid,
    output logic [4*CW+7:0]         num [lci_pkg::N_LANES],
    output logic [2*CW+1:0]         den,
    output logic [lci_pkg::N_LANES-1:0] neg,
    output logic signed [CW-1:0]    out_sx,
    output logic signed [CW-1:0]    out_sy,
    output lci_pkg::lci_sel_t       sel
);
    import lci_pkg::*;

    localparam int DW  = CW + 1;
    localparam int AW  = 2 * CW + 1;
    localparam int NW  = 2 * CW + 4;
    localparam int L2  = CW + 2;
    localparam int HN  = NW - L2;
    localparam int MW  = DW + NW;
    localparam int NDW = 4 * CW + 8;

    logic [2:0] v_reg;

    logic signed [NW-1:0] n0, n1;
    logic                 in0, in1;

    logic [NW-1:0]        p1_nm0_reg, p1_nm1_reg;
    logic                 p1_nn0_reg, p1_nn1_reg;
    logic [DW-1:0]        p1_dxm_reg, p1_dym_reg;
    logic                 p1_dxn_reg, p1_dyn_reg;
    logic [AW-1:0]        a_reg  [3];
    logic signed [CW-1:0] sx_reg [3];
    logic signed [CW-1:0] sy_reg [3];
    lci_sel_t             sel_reg [3];

    logic [DW+L2-1:0]     p2_lo_reg  [N_LANES];
    logic [DW+HN-1:0]     p2_hi_reg  [N_LANES];
    logic [N_LANES-1:0]   p2_neg_reg, p3_neg_reg;
    logic [NDW-1:0]       p3_num_reg [N_LANES];
    logic [AW:0]          p3_den_reg;

    assign n0  = $signed(NW'(s)) - NW'(h);
    assign n1  = -NW'(h) - $signed(NW'(s));
    assign in0 = !n0[NW-1] && (n0 <= $signed(NW'(a)));
    assign in1 = !n1[NW-1] && (n1 <= $signed(NW'(a)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_nm0_reg <= n0[NW-1] ? NW'(-n0) : NW'(n0);
            p1_nm1_reg <= n1[NW-1] ? NW'(-n1) : NW'(n1);
            p1_nn0_reg <= n0[NW-1];
            p1_nn1_reg <= n1[NW-1];
            p1_dxm_reg <= dx[DW-1] ? DW'(-dx) : DW'(dx);
            p1_dym_reg <= dy[DW-1] ? DW'(-dy) : DW'(dy);
            p1_dxn_reg <= dx[DW-1];
            p1_dyn_reg <= dy[DW-1];
            a_reg[0]   <= a;
            sx_reg[0]  <= sx;
            sy_reg[0]  <= sy;
            sel_reg[0].keep0    <= !zl && !qneg && (!func || in0);
            sel_reg[0].keep1    <= !zl && !qneg && !qzero && (!func || in1);
            sel_reg[0].zero_len <= zl;
            for (int i = 1; i < 3; i++)
            begin
                a_reg[i]   <= a_reg[i-1];
                sx_reg[i]  <= sx_reg[i-1];
                sy_reg[i]  <= sy_reg[i-1];
                sel_reg[i] <= sel_reg[i-1];
            end
            p3_neg_reg <= p2_neg_reg;
            p3_den_reg <= {a_reg[1], 1'b0};
        end
    end

    for (genvar l = 0; l < N_LANES; l++)
    begin : g_lane
        localparam bit IS_Y   = (l == LANE_P0Y) || (l == LANE_P1Y);
        localparam bit IS_TWO = (l == LANE_P1X) || (l == LANE_P1Y);
        logic [DW-1:0] dk;
        logic          dkn;
        logic [NW-1:0] nm;
        logic          nn;

        assign dk  = IS_Y ? p1_dym_reg : p1_dxm_reg;
        assign dkn = IS_Y ? p1_dyn_reg : p1_dxn_reg;
        assign nm  = IS_TWO ? p1_nm1_reg : p1_nm0_reg;
        assign nn  = IS_TWO ? p1_nn1_reg : p1_nn0_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p2_lo_reg[l]  <= dk * nm[L2-1:0];
                p2_hi_reg[l]  <= dk * nm[NW-1:L2];
                p2_neg_reg[l] <= dkn ^ nn;
                // 2*|Dk*n| + a, so that floor(./2a) rounds half away from zero
                p3_num_reg[l] <= ((NDW'(p2_lo_reg[l]) + (NDW'(p2_hi_reg[l]) << L2)) << 1)
                               + NDW'(a_reg[1]);
            end
        end

        assign num[l] = p3_num_reg[l];
    end

    assign out_valid = v_reg[2];
    assign den       = p3_den_reg;
    assign neg       = p3_neg_reg;
    assign out_sx    = sx_reg[2];
    assign out_sy    = sy_reg[2];
    assign sel       = sel_reg[2];

endmodule
`default_nettype wire

[src/lci_div.sv]
// lci_div: four-lane pipelined restoring divider, one quotient bit per stage,
// with an overflow flag for quotients that do not fit. Uses lci_pkg.
`default_nettype none
module lci_div #(
    parameter int NDW  = 72,
    parameter int DENW = 34,
    parameter int QB   = 18,
    parameter int PW   = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [NDW-1:0]               num [lci_pkg::N_LANES],
    input  logic [DENW-1:0]              den,
    input  logic [PW-1:0]                in_pay,
    output logic                         out_valid,
    output logic [QB-1:0]                quo [lci_pkg::N_LANES],
    output logic [lci_pkg::N_LANES-1:0]  ovf,
    output logic [PW-1:0]                out_pay
);
    import lci_pkg::*;

    logic [QB-1:0]      v_reg;
    logic [NDW-1:0]     rem_reg [QB-1][N_LANES];
    logic [QB-1:0]      quo_reg [QB][N_LANES];
    logic [N_LANES-1:0] ovf_reg [QB];
    logic [DENW-1:0]    den_reg [QB-1];
    logic [PW-1:0]      pay_reg [QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[QB-2:0], in_valid};
        end
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_stage
        localparam int K = QB - 1 - j;
        logic [DENW-1:0]    den_in;
        logic [PW-1:0]      pay_in;
        logic [N_LANES-1:0] ovf_in;
        logic [NDW-1:0]     sh;

        if (j == 0)
        begin : g_first
            assign den_in = den;
            assign pay_in = in_pay;
        end
        else
        begin : g_rest
            assign den_in = den_reg[j-1];
            assign pay_in = pay_reg[j-1];
            assign ovf_in = ovf_reg[j-1];
        end

        assign sh = NDW'(den_in) << K;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pay_reg[j] <= pay_in;
                ovf_reg[j] <= ovf_in;
            end
        end

        if (j < QB - 1)
        begin : g_den
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[j] <= den_in;
                end
            end
        end

        for (genvar l = 0; l < N_LANES; l++)
        begin : g_lane
            logic [NDW-1:0] rem_in;
            logic [QB-1:0]  quo_in;
            logic           ge;

            if (j == 0)
            begin : g_first
                assign rem_in    = num[l];
                assign quo_in    = '0;
                assign ovf_in[l] = num[l] >= (NDW'(den) << QB);
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[j-1][l];
                assign quo_in = quo_reg[j-1][l];
            end

            assign ge = rem_in >= sh;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quo_reg[j][l] <= {quo_in[QB-2:0], ge};
                end
            end

            if (j < QB - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[j][l] <= ge ? rem_in - sh : rem_in;
                    end
                end
            end
        end
    end

    for (genvar l = 0; l < N_LANES; l++)
    begin : g_quo
        assign quo[l] = quo_reg[QB-1][l];
    end

    assign out_valid = v_reg[QB-1];
    assign ovf       = ovf_reg[QB-1];
    assign out_pay   = pay_reg[QB-1];

endmodule
`default_nettype wire

[src/line_circle_intersection.sv]
// line_circle_intersection: top level, line or segment against circle.
// Uses lci_pkg, lci_if, lci_quad, lci_sqrt, lci_numer, lci_div.
//
//  channel  | dir | payload
//  ---------+-----+---------------------------------------------------------
//  in_ch    | in  | func, start_x/y, end_x/y, center_x/y, radius
//  out_ch   | out | hit, point_count, first_x/y, second_x/y, zero_length
//
// Fully pipelined, one request per cycle while out_ch is not stalled. The stages
// are quadratic setup, square root, numerators, dividers and an output
// register.
// A result held on out_ch freezes the whole pipeline; nothing is lost.
// Reset clears the valid bits only.
`default_nettype none
module line_circle_intersection #(
    parameter int COORD_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    lci_in_if.sink    in_ch,
    lci_out_if.source out_ch
);
    import lci_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int DW   = CW + 1;
    localparam int AW   = 2 * CW + 1;
    localparam int HW   = 2 * CW + 2;
    localparam int QW   = 4 * CW + 4;
    localparam int SW   = QW / 2;
    localparam int NDW  = 4 * CW + 8;
    localparam int QB   = CW + 2;
    localparam int XW   = CW + 4;
    localparam int SQPW = 4 + AW + HW + 2 * CW + 2 * DW;
    localparam int DVPW = N_LANES + 3 + 2 * CW;
    localparam logic signed [XW-1:0] XMAX = XW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [XW-1:0] XMIN = -XMAX - XW'(1);

    logic en;
    logic out_v_reg;

    // front end
    logic                 qd_valid, qd_func;
    logic signed [QW-1:0] qd_q;
    logic [AW-1:0]        qd_a;
    logic signed [HW-1:0] qd_h;
    logic signed [CW-1:0] qd_sx, qd_sy;
    logic signed [DW-1:0] qd_dx, qd_dy;

    // square root
    logic [QW-1:0]        sq_rad;
    logic [SQPW-1:0]      sq_pay_in, sq_pay_out;
    logic                 sq_valid;
    logic [SW-1:0]        sq_root;
    logic                 sq_func, sq_zl, sq_qneg, sq_qzero;
    logic [AW-1:0]        sq_a;
    logic signed [HW-1:0] sq_h;
    logic signed [CW-1:0] sq_sx, sq_sy;
    logic signed [DW-1:0] sq_dx, sq_dy;

    // numerators
    logic                 nm_valid;
    logic [NDW-1:0]       nm_num [N_LANES];
    logic [AW:0]          nm_den;
    logic [N_LANES-1:0]   nm_neg;
    logic signed [CW-1:0] nm_sx, nm_sy;
    lci_sel_t             nm_sel;

    // dividers
    logic                 dv_valid;
    logic [QB-1:0]        dv_quo [N_LANES];
    logic [N_LANES-1:0]   dv_ovf;
    logic [DVPW-1:0]      dv_pay;
    logic [N_LANES-1:0]   dv_neg;
    lci_sel_t             dv_sel;
    logic signed [CW-1:0] dv_sx, dv_sy;

    logic signed [CW-1:0] pt [N_LANES];

    logic                 hit_reg, zl_reg;
    logic [1:0]           cnt_reg;
    logic signed [CW-1:0] fx_reg, fy_reg, sx2_reg, sy2_reg;

    assign en          = !out_v_reg || out_ch.ready;
    assign in_ch.ready = en;

    lci_quad #(.CW(CW)) u_quad (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_ch.valid),
        .in_func   (in_ch.func),
        .sx        (in_ch.start_x),
        .sy        (in_ch.start_y),
        .ex        (in_ch.end_x),
        .ey        (in_ch.end_y),
        .cx        (in_ch.center_x),
        .cy        (in_ch.center_y),
        .r         (in_ch.radius),
        .out_valid (qd_valid),
        .out_func  (qd_func),
        .q         (qd_q),
        .a         (qd_a),
        .h         (qd_h),
        .out_sx    (qd_sx),
        .out_sy    (qd_sy),
        .dx        (qd_dx),
        .dy        (qd_dy)
    );

    assign sq_rad    = qd_q[QW-1] ? '0 : qd_q;
    assign sq_pay_in = {qd_func, (qd_a == '0), qd_q[QW-1], (qd_q == '0),
                        qd_a, qd_h, qd_sx, qd_sy, qd_dx, qd_dy};

    lci_sqrt #(.QW(QW), .PW(SQPW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (qd_valid),
        .rad       (sq_rad),
        .in_pay    (sq_pay_in),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_pay   (sq_pay_out)
    );

    assign {sq_func, sq_zl, sq_qneg, sq_qzero, sq_a, sq_h, sq_sx, sq_sy, sq_dx, sq_dy}
        = sq_pay_out;

    lci_numer #(.CW(CW)) u_numer (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .s         (sq_root),
        .a         (sq_a),
        .h         (sq_h),
        .sx        (sq_sx),
        .sy        (sq_sy),
        .dx        (sq_dx),
        .dy        (sq_dy),
        .func      (sq_func),
        .zl        (sq_zl),
        .qneg      (sq_qneg),
        .qzero     (sq_qzero),
        .out_valid (nm_valid),
        .num       (nm_num),
        .den       (nm_den),
        .neg       (nm_neg),
        .out_sx    (nm_sx),
        .out_sy    (nm_sy),
        .sel       (nm_sel)
    );

    lci_div #(.NDW(NDW), .DENW(AW + 1), .QB(QB), .PW(DVPW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nm_valid),
        .num       (nm_num),
        .den       (nm_den),
        .in_pay    ({nm_neg, nm_sel, nm_sx, nm_sy}),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .ovf       (dv_ovf),
        .out_pay   (dv_pay)
    );

    assign {dv_neg, dv_sel, dv_sx, dv_sy} = dv_pay;

    for (genvar l = 0; l < N_LANES; l++)
    begin : g_pt
        localparam bit IS_Y = (l == LANE_P0Y) || (l == LANE_P1Y);
        logic signed [XW-1:0] base;
        logic signed [XW-1:0] off;
        logic signed [XW-1:0] x;

        assign base = IS_Y ? XW'(dv_sy) : XW'(dv_sx);
        assign off  = $signed({{(XW - QB){1'b0}}, dv_quo[l]});
        assign x    = dv_neg[l] ? base - off : base + off;

        always_comb
        begin
            if (dv_ovf[l])
            begin
                pt[l] = dv_neg[l] ? CW'(XMIN) : CW'(XMAX);
            end
            else if (x > XMAX)
            begin
                pt[l] = CW'(XMAX);
            end
            else if (x < XMIN)
            begin
                pt[l] = CW'(XMIN);
            end
            else
            begin
                pt[l] = CW'(x);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= dv_valid;
        end
    end

    // lone kept root goes to the first slot
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= dv_sel.keep0 || dv_sel.keep1;
            cnt_reg <= {dv_sel.keep0 && dv_sel.keep1, dv_sel.keep0 ^ dv_sel.keep1};
            zl_reg  <= dv_sel.zero_len;
            fx_reg  <= dv_sel.keep0 ? pt[LANE_P0X] : (dv_sel.keep1 ? pt[LANE_P1X] : '0);
            fy_reg  <= dv_sel.keep0 ? pt[LANE_P0Y] : (dv_sel.keep1 ? pt[LANE_P1Y] : '0);
            sx2_reg <= (dv_sel.keep0 && dv_sel.keep1) ? pt[LANE_P1X] : '0;
            sy2_reg <= (dv_sel.keep0 && dv_sel.keep1) ? pt[LANE_P1Y] : '0;
        end
    end

    assign out_ch.valid       = out_v_reg;
    assign out_ch.hit         = hit_reg;
    assign out_ch.point_count = cnt_reg;
    assign out_ch.first_x     = fx_reg;
    assign out_ch.first_y     = fy_reg;
    assign out_ch.second_x    = sx2_reg;
    assign out_ch.second_y    = sy2_reg;
    assign out_ch.zero_length = zl_reg;

endmodule
`default_nettype wire

[src/lci_chk.sv]
// lci_chk: port-level checks on the result channel, bound to the top level.
// Depends on line_circle_intersection and lci_out_if.
`default_nettype none
module lci_chk #(
    parameter int CW = 16
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 valid,
    input logic                 ready,
    input logic                 hit,
    input logic [1:0]           point_count,
    input logic signed [CW-1:0] first_x,
    input logic signed [CW-1:0] first_y,
    input logic signed [CW-1:0] second_x,
    input logic signed [CW-1:0] second_y,
    input logic                 zero_length
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable({hit, point_count, first_x, first_y,
                                             second_x, second_y, zero_length}))
        else $error("result changed while stalled");

    a_hit: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> hit == (point_count != 2'd0))
        else $error("hit does not match point count");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && zero_length |-> point_count == 2'd0 && first_x == '0 && first_y == '0)
        else $error("zero-length request reported points");

    a_second: assert property (@(posedge clk) disable iff (!rst_n)
        valid && point_count != 2'd2 |-> second_x == '0 && second_y == '0)
        else $error("second point set without two points");

endmodule

bind line_circle_intersection lci_chk #(.CW(COORD_BITS)) u_lci_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (out_ch.valid),
    .ready       (out_ch.ready),
    .hit         (out_ch.hit),
    .point_count (out_ch.point_count),
    .first_x     (out_ch.first_x),
    .first_y     (out_ch.first_y),
    .second_x    (out_ch.second_x),
    .second_y    (out_ch.second_y),
    .zero_length (out_ch.zero_length)
);
`default_nettype wire
